// File: rtl/adm_pkg.sv
package adm_pkg;

    localparam int LETTER_W = 8;
    localparam int LEN_W    = 3;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_LOADED  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

endpackage

// File: rtl/anagram_dictionary_match.sv
// Channel   Handshake                   Payload
// word      word_valid / word_stall     opcode, word_letters, word_length
// result    result_valid / result_stall status, match_letters, match_length, last
//
// After accept the letter sorter builds the signature. A load then shifts larger entries
// up one slot and writes the new one, a load into a full table reports ST_FULL, and a
// query reads the entries in turn (one table read per entry, one entry per cycle unless a
// second match waits on a held result). result_stall also holds the final result in S_FIN.
// word_stall is high until the block is back in S_IDLE, so the next transaction can be
// taken in the cycle the final result appears. Reset clears state, count and valid flags.
module anagram_dictionary_match #(
    parameter int DICT_ENTRIES = 64,
    parameter int MAX_LETTERS  = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          word_valid,
    output logic                          word_stall,
    input  logic                          opcode,
    input  logic [8*MAX_LETTERS-1:0]      word_letters,
    input  logic [adm_pkg::LEN_W-1:0]     word_length,

    output logic                          result_valid,
    input  logic                          result_stall,
    output adm_pkg::status_t              status,
    output logic [8*MAX_LETTERS-1:0]      match_letters,
    output logic [adm_pkg::LEN_W-1:0]     match_length,
    output logic                          last
);
    import adm_pkg::*;

    localparam int WORD_W = LETTER_W * MAX_LETTERS;
    localparam int IDX_W  = $clog2(DICT_ENTRIES);
    localparam int CNT_W  = $clog2(DICT_ENTRIES + 1);
    localparam int ENT_W  = 2 * WORD_W + LEN_W;   // {letters, signature, length}

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SORT    = 6'b000010,
        S_INS_CMP = 6'b000100,
        S_INS_WR  = 6'b001000,
        S_QRY     = 6'b010000,
        S_FIN     = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    opcode_t           op_reg, op_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    status_t           fin_reg, fin_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0] pend_letters_reg, pend_letters_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [WORD_W-1:0] out_letters_reg, out_letters_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;
    logic              out_free;

    // Input cleanup: clamp length, zero the bytes past it.
    logic [LEN_W-1:0]  len_clamp;
    logic [WORD_W-1:0] word_clean;

    always_comb
    begin
        len_clamp = ({1'b0, word_length} > 4'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS)
                                                            : word_length;
        for (int i = 0; i < MAX_LETTERS; i++)
        begin
            word_clean[WORD_W-LETTER_W*(i+1) +: LETTER_W] =
                (4'(i) < {1'b0, len_clamp}) ? word_letters[WORD_W-LETTER_W*(i+1) +: LETTER_W]
                                            : '0;
        end
    end

    // Letter sorter builds the signature of the current word.
    logic              sort_start;
    logic              sort_done;
    logic [WORD_W-1:0] sort_sig;

    adm_sorter #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .word  (word_next),
        .len   (len_next),
        .done  (sort_done),
        .sig   (sort_sig)
    );

    // Dictionary table.
    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_wr_addr;
    logic [ENT_W-1:0]  tbl_wr_data;
    logic              tbl_rd_en;
    logic [IDX_W-1:0]  tbl_rd_addr;
    logic [ENT_W-1:0]  tbl_rd_data;

    adm_table #(
        .DEPTH  (DICT_ENTRIES),
        .DATA_W (ENT_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    logic [WORD_W-1:0] rd_letters;
    logic [WORD_W-1:0] rd_sig;
    logic [LEN_W-1:0]  rd_len;
    logic [ENT_W-1:0]  new_entry;
    logic              entry_after;
    logic              entry_hit;
    logic              table_full;
    logic              walk_more;

    assign rd_letters  = tbl_rd_data[ENT_W-1 -: WORD_W];
    assign rd_sig      = tbl_rd_data[LEN_W +: WORD_W];
    assign rd_len      = tbl_rd_data[LEN_W-1:0];
    assign new_entry   = {word_reg, sort_sig, len_reg};
    // Order: packed letters as unsigned, then length; equal words insert after.
    assign entry_after = (rd_letters > word_reg) ||
                         ((rd_letters == word_reg) && (rd_len > len_reg));
    assign entry_hit   = (rd_len == len_reg) && (rd_sig == sort_sig);
    assign table_full  = (count_reg == CNT_W'(DICT_ENTRIES));
    assign walk_more   = ((CNT_W'(pos_reg) + CNT_W'(1)) < count_reg);
    assign out_free    = !out_valid_reg || !result_stall;

    // Sequencer. Reads and writes never target the same entry in one cycle:
    // the insert shifts upward writing pos while reading pos-2, and a query
    // only starts after the previous insert's last write has landed.
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        word_next         = word_reg;
        len_next          = len_reg;
        count_next        = count_reg;
        pos_next          = pos_reg;
        fin_next          = fin_reg;
        pend_valid_next   = pend_valid_reg;
        pend_letters_next = pend_letters_reg;
        pend_len_next     = pend_len_reg;
        sort_start        = 1'b0;
        tbl_wr_en         = 1'b0;
        tbl_wr_addr       = pos_reg;
        tbl_wr_data       = new_entry;
        tbl_rd_en         = 1'b0;
        tbl_rd_addr       = pos_reg;
        out_load          = 1'b0;
        out_status_next   = out_status_reg;
        out_letters_next  = out_letters_reg;
        out_len_next      = out_len_reg;
        out_last_next     = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (word_valid)
                begin
                    op_next    = opcode_t'(opcode);
                    word_next  = word_clean;
                    len_next   = len_clamp;
                    sort_start = 1'b1;
                    state_next = S_SORT;
                end
            end

            S_SORT:
            begin
                if (sort_done)
                begin
                    if (op_reg == OP_LOAD)
                    begin
                        if (table_full)
                        begin
                            fin_next   = ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            pos_next = count_reg[IDX_W-1:0];
                            if (count_reg == '0)
                            begin
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                tbl_rd_en   = 1'b1;
                                tbl_rd_addr = count_reg[IDX_W-1:0] - IDX_W'(1);
                                state_next  = S_INS_CMP;
                            end
                        end
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        pos_next        = '0;
                        if (count_reg == '0)
                        begin
                            fin_next   = ST_NOMATCH;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            tbl_rd_en   = 1'b1;
                            tbl_rd_addr = '0;
                            state_next  = S_QRY;
                        end
                    end
                end
            end

            S_INS_CMP:
            begin
                tbl_wr_en = 1'b1;
                if (entry_after)
                begin
                    // shift the larger entry up one slot
                    tbl_wr_data = tbl_rd_data;
                    if (pos_reg == IDX_W'(1))
                    begin
                        pos_next   = '0;
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        pos_next    = pos_reg - IDX_W'(1);
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = pos_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    fin_next   = ST_LOADED;
                    state_next = S_FIN;
                end
            end

            S_INS_WR:
            begin
                tbl_wr_en  = 1'b1;
                count_next = count_reg + CNT_W'(1);
                fin_next   = ST_LOADED;
                state_next = S_FIN;
            end

            S_QRY:
            begin
                // A second hit pushes the held one out; wait if the output is busy.
                if (!(entry_hit && pend_valid_reg && !out_free))
                begin
                    if (entry_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load         = 1'b1;
                            out_status_next  = ST_MATCH;
                            out_letters_next = pend_letters_reg;
                            out_len_next     = pend_len_reg;
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next   = 1'b1;
                        pend_letters_next = rd_letters;
                        pend_len_next     = rd_len;
                    end
                    if (walk_more)
                    begin
                        pos_next    = pos_reg + IDX_W'(1);
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = pos_reg + IDX_W'(1);
                    end
                    else
                    begin
                        fin_next   = (entry_hit || pend_valid_reg) ? ST_MATCH : ST_NOMATCH;
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = fin_reg;
                    out_last_next   = 1'b1;
                    if (fin_reg == ST_MATCH)
                    begin
                        out_letters_next = pend_letters_reg;
                        out_len_next     = pend_len_reg;
                    end
                    else
                    begin
                        out_letters_next = '0;
                        out_len_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        word_reg         <= word_next;
        len_reg          <= len_next;
        pos_reg          <= pos_next;
        fin_reg          <= fin_next;
        pend_letters_reg <= pend_letters_next;
        pend_len_reg     <= pend_len_next;
        out_status_reg   <= out_status_next;
        out_letters_reg  <= out_letters_next;
        out_len_reg      <= out_len_next;
        out_last_reg     <= out_last_next;
    end

    assign word_stall    = (state_reg != S_IDLE);
    assign result_valid  = out_valid_reg;
    assign status        = out_status_reg;
    assign match_letters = out_letters_reg;
    assign match_length  = out_len_reg;
    assign last          = out_last_reg;

    // Checks

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DICT_ENTRIES))
        else $error("entry count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |-> (state_reg == S_INS_CMP) || (state_reg == S_INS_WR))
        else $error("table write outside insert");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_WR) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not bump entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_MATCH)) |-> (last && (match_length == '0)))
        else $error("non-match result must be final and empty");

endmodule

// File: rtl/adm_sorter.sv
// Odd-even transposition sort, one phase per cycle.
// Letters past the length carry a flag bit so they sort to the end as zero bytes.
module adm_sorter #(
    parameter int MAX_LETTERS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [8*MAX_LETTERS-1:0]    word,
    input  logic [adm_pkg::LEN_W-1:0]   len,
    output logic                        done,
    output logic [8*MAX_LETTERS-1:0]    sig
);
    import adm_pkg::*;

    localparam int WORD_W = LETTER_W * MAX_LETTERS;
    localparam int PH_W   = $clog2(MAX_LETTERS);

    logic [LETTER_W:0] key_reg  [MAX_LETTERS];
    logic [LETTER_W:0] key_next [MAX_LETTERS];
    logic [PH_W-1:0]   phase_reg;
    logic              running_reg;
    logic              done_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_LETTERS; i++)
        begin
            key_next[i] = key_reg[i];
        end
        for (int i = 0; i < MAX_LETTERS - 1; i++)
        begin
            if (((i % 2) == int'(phase_reg[0])) && (key_reg[i] > key_reg[i+1]))
            begin
                key_next[i]   = key_reg[i+1];
                key_next[i+1] = key_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < MAX_LETTERS; i++)
            begin
                key_reg[i] <= {(4'(i) >= {1'b0, len}), word[WORD_W-LETTER_W*(i+1) +: LETTER_W]};
            end
        end
        else if (running_reg)
        begin
            for (int i = 0; i < MAX_LETTERS; i++)
            begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            phase_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                phase_reg   <= '0;
            end
            else if (running_reg)
            begin
                if (phase_reg == PH_W'(MAX_LETTERS - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
                else
                begin
                    phase_reg <= phase_reg + PH_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_LETTERS; i++)
        begin
            sig[WORD_W-LETTER_W*(i+1) +: LETTER_W] = key_reg[i][LETTER_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/adm_table.sv
// Simple dual-port table, registered read.
module adm_table #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 99
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: verif/anagram_dictionary_match_tb.sv
`timescale 1ns / 100ps

module anagram_dictionary_match_tb;

    import adm_pkg::*;

    localparam int DICT_ENTRIES = 64;
    localparam int MAX_LETTERS  = 6;
    localparam int WORD_W       = 8 * MAX_LETTERS;

    // Random section: four phases, each with its own idling pattern.
    localparam int RANDOM_WORDS  = 300;
    localparam int PHASE_WORDS   = 75;
    // Enough loads to overflow the table a few times before the run ends.
    localparam int TARGET_LOADS  = 70;
    localparam int HEAVY_PCT     = 49;
    localparam int MIXED_PCT     = 33;
    // Longest quiet stretch of a correct run is one full-table walk plus
    // stalls; this is many times that.
    localparam int WATCHDOG_LIMIT = 3000;
    // Tail after the last answer, longer than one load into a full table.
    localparam int SETTLE_CYCLES  = 100;

    typedef enum logic [1:0] {
        IDLE_NONE     = 2'd0,
        IDLE_SENDER   = 2'd1,
        IDLE_RECEIVER = 2'd2,
        IDLE_BOTH     = 2'd3
    } idle_mode_t;

    // One word-channel transaction plus how the driver should present it.
    typedef struct packed {
        opcode_t           op;
        logic [WORD_W-1:0] letters;
        logic [LEN_W-1:0]  len;
        logic              drain;  // hold off until every answer is back
        idle_mode_t        mode;
    } word_txn_t;

    // One result-channel transaction.
    typedef struct packed {
        status_t           st;
        logic [WORD_W-1:0] letters;
        logic [LEN_W-1:0]  len;
        logic              last;
    } answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              word_valid = 1'b0;
    logic              word_stall;
    opcode_t           opcode = OP_LOAD;
    logic [WORD_W-1:0] word_letters = '0;
    logic [LEN_W-1:0]  word_length = '0;

    logic              result_valid;
    logic              result_stall = 1'b0;
    status_t           status;
    logic [WORD_W-1:0] match_letters;
    logic [LEN_W-1:0]  match_length;
    logic              last;

    word_txn_t         word_backlog[$];   // words not yet handed to the block
    word_txn_t         loaded_words[$];   // every load queued, for anagram picks
    answer_t           answers_due[$];    // answers the block still owes
    word_txn_t         in_flight;
    idle_mode_t        cur_mode = IDLE_NONE;
    int                fail_count = 0;
    int                quiet_cycles = 0;
    int                sent_count = 0;    // word transactions accepted so far

    // Mirror of the dictionary, updated when a word is accepted.
    logic [WORD_W-1:0] dict_word [DICT_ENTRIES];
    logic [WORD_W-1:0] dict_key  [DICT_ENTRIES];
    logic [LEN_W-1:0]  dict_len  [DICT_ENTRIES];
    int                dict_count = 0;

    anagram_dictionary_match #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .MAX_LETTERS  (MAX_LETTERS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .opcode        (opcode),
        .word_letters  (word_letters),
        .word_length   (word_length),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .match_letters (match_letters),
        .match_length  (match_length),
        .last          (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one accepted word to the mirror table and queue the
    // answers it must produce.
    // ------------------------------------------------------------------
    task automatic apply_to_dictionary(input word_txn_t t);
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] key;
        logic [7:0]        ch [MAX_LETTERS];
        logic [7:0]        v;
        logic [LEN_W-1:0]  n;
        answer_t           a;
        int                i;
        int                j;
        int                pos;
        int                hits;

        // Lengths past the table width clip; bytes past the length are dropped.
        n    = (t.len > MAX_LETTERS) ? LEN_W'(MAX_LETTERS) : t.len;
        word = '0;
        key  = '0;
        for (i = 0; i < n; i++)
        begin
            ch[i] = t.letters[8*(MAX_LETTERS-1-i) +: 8];
            word[8*(MAX_LETTERS-1-i) +: 8] = ch[i];
        end
        // Anagram key: letters in ascending unsigned order.
        for (i = 1; i < n; i++)
        begin
            v = ch[i];
            j = i;
            while (j > 0 && ch[j-1] > v)
            begin
                ch[j] = ch[j-1];
                j--;
            end
            ch[j] = v;
        end
        for (i = 0; i < n; i++)
            key[8*(MAX_LETTERS-1-i) +: 8] = ch[i];

        a.letters = '0;
        a.len     = '0;
        a.last    = 1'b1;

        if (t.op == OP_LOAD)
        begin
            if (dict_count >= DICT_ENTRIES)
                a.st = ST_FULL;
            else
            begin
                // Sorted by packed letters then length; equal words go after.
                pos = dict_count;
                while (pos > 0 && {dict_word[pos-1], dict_len[pos-1]} > {word, n})
                begin
                    dict_word[pos] = dict_word[pos-1];
                    dict_key[pos]  = dict_key[pos-1];
                    dict_len[pos]  = dict_len[pos-1];
                    pos--;
                end
                dict_word[pos] = word;
                dict_key[pos]  = key;
                dict_len[pos]  = n;
                dict_count++;
                a.st = ST_LOADED;
            end
            answers_due.push_back(a);
        end
        else
        begin
            hits = 0;
            for (i = 0; i < dict_count; i++)
            begin
                if (dict_len[i] == n && dict_key[i] == key)
                begin
                    a.st      = ST_MATCH;
                    a.letters = dict_word[i];
                    a.len     = dict_len[i];
                    a.last    = 1'b0;
                    answers_due.push_back(a);
                    hits++;
                end
            end
            if (hits == 0)
            begin
                a.st = ST_NOMATCH;
                answers_due.push_back(a);
            end
            else
            begin
                // Flag the final match of this query.
                a = answers_due.pop_back();
                a.last = 1'b1;
                answers_due.push_back(a);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input opcode_t op, input logic [WORD_W-1:0] letters,
                              input int len, input logic drain, input idle_mode_t mode);
        word_txn_t t;
        t.op      = op;
        t.letters = letters;
        t.len     = LEN_W'(len);
        t.drain   = drain;
        t.mode    = mode;
        word_backlog.push_back(t);
        if (op == OP_LOAD)
            loaded_words.push_back(t);
    endtask

    // Narrow alphabet (a..d) makes anagram families common; wide covers all bits.
    function automatic logic [WORD_W-1:0] random_letters(input int len, input bit wide);
        logic [WORD_W-1:0] w;
        int                i;
        w = '0;
        for (i = 0; i < len && i < MAX_LETTERS; i++)
            w[8*(MAX_LETTERS-1-i) +: 8] = wide ? 8'($urandom_range(255))
                                               : 8'(8'h61 + $urandom_range(3));
        return w;
    endfunction

    // Random permutation of the used letters; tail cleared.
    function automatic logic [WORD_W-1:0] shuffled(input logic [WORD_W-1:0] w,
                                                   input int len);
        logic [7:0]        ch [MAX_LETTERS];
        logic [7:0]        tmp;
        logic [WORD_W-1:0] r;
        int                n;
        int                i;
        int                j;
        n = (len > MAX_LETTERS) ? MAX_LETTERS : len;
        r = '0;
        for (i = 0; i < n; i++)
            ch[i] = w[8*(MAX_LETTERS-1-i) +: 8];
        for (i = n - 1; i > 0; i--)
        begin
            j      = $urandom_range(i);
            tmp    = ch[i];
            ch[i]  = ch[j];
            ch[j]  = tmp;
        end
        for (i = 0; i < n; i++)
            r[8*(MAX_LETTERS-1-i) +: 8] = ch[i];
        return r;
    endfunction

    // Garbage in the bytes past the length; the block must ignore it.
    function automatic logic [WORD_W-1:0] with_junk(input logic [WORD_W-1:0] w,
                                                    input int len);
        int i;
        for (i = len; i < MAX_LETTERS; i++)
            w[8*(MAX_LETTERS-1-i) +: 8] = 8'($urandom_range(255));
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Word driver: presents the backlog, idles per the word's mode, holds a
    // stalled transaction steady, and feeds accepted words to the predictor.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        word_txn_t nxt;
        logic      present;
        int        pct;
        if (!rst_n)
        begin
            word_valid   <= 1'b0;
            opcode       <= OP_LOAD;
            word_letters <= '0;
            word_length  <= '0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                apply_to_dictionary(in_flight);
                sent_count++;
            end
            if (!word_valid || !word_stall)
            begin
                present = 1'b0;
                if (word_backlog.size() != 0)
                begin
                    nxt = word_backlog[0];
                    case (nxt.mode)
                        IDLE_SENDER: pct = HEAVY_PCT;
                        IDLE_BOTH:   pct = MIXED_PCT;
                        default:     pct = 0;
                    endcase
                    if (!(nxt.drain && answers_due.size() != 0)
                        && $urandom_range(99) >= pct)
                        present = 1'b1;
                end
                if (present)
                begin
                    in_flight     = word_backlog.pop_front();
                    cur_mode     <= in_flight.mode;
                    opcode       <= in_flight.op;
                    word_letters <= in_flight.letters;
                    word_length  <= in_flight.len;
                end
                else
                begin
                    // Idle: payload is don't-care, so scramble it.
                    opcode       <= opcode_t'($urandom_range(1));
                    word_letters <= WORD_W'({$urandom, $urandom});
                    word_length  <= LEN_W'($urandom_range(7));
                end
                word_valid <= present;
            end
        end
    end

    // Result-side stall, following the mode of the latest word sent.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            case (cur_mode)
                IDLE_RECEIVER: result_stall <= ($urandom_range(99) < HEAVY_PCT);
                IDLE_BOTH:     result_stall <= ($urandom_range(99) < MIXED_PCT);
                default:       result_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each accepted transaction against the oldest answer due.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result: status %0d letters %h length %0d last %0b",
                       status, match_letters, match_length, last);
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (match_letters !== want.letters)
                begin
                    $error("match_letters: expected %h, got %h", want.letters, match_letters);
                    fail_count++;
                end
                if (match_length !== want.len)
                begin
                    $error("match_length: expected %0d, got %0d", want.len, match_length);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no transaction on either channel means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (word_valid && !word_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        word_txn_t         src;
        logic [WORD_W-1:0] w;
        idle_mode_t        mode;
        int                k;
        int                len;
        int                pick;
        int                loads;
        int                total;
        bit                do_load;

        // Directed: empty-table miss, anagram family with a duplicate,
        // junk past the length, clipped length, zero and 0xFF letters,
        // zero-byte ordering, the empty word, high-bit letters.
        queue_word(OP_QUERY, {"cat", 24'h0}, 3, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {"post", 16'h0}, 4, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {"stop", 16'h0}, 4, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {"tops", 16'h0}, 4, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {"pots", 16'h0}, 4, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {"stop", 16'h0}, 4, 1'b0, IDLE_NONE);
        // Sender holds off here until the loads are all answered.
        queue_word(OP_QUERY, {"opts", 16'h0}, 4, 1'b1, IDLE_NONE);
        queue_word(OP_QUERY, {"spot", 16'hA5C3}, 4, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, {"spot", 16'h0}, 3, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  48'hFFFF_FFFF_FFFF, 6, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, 48'hFFFF_FFFF_FFFF, 7, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  48'h0, 6, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {"a", 40'h0}, 2, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {"a", 40'hFF_FFFF_FFFF}, 1, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, {"a", 40'h0}, 1, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, {8'h00, "a", 32'h0}, 2, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, 48'h0, 6, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  48'h1234_5678_9ABC, 0, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, 48'hDEAD_BEEF_0000, 0, 1'b0, IDLE_NONE);
        queue_word(OP_LOAD,  {8'h80, 8'h7F, 32'h0}, 2, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, {8'h7F, 8'h80, 32'h0}, 2, 1'b0, IDLE_NONE);
        queue_word(OP_QUERY, {8'h80, 8'h80, 32'h0}, 2, 1'b0, IDLE_NONE);
        loads = loaded_words.size();

        // Random: mostly anagrams of stored words so queries hit, plus fresh
        // words and wide noise. Loads are forced late if needed so the
        // table overflows before the end.
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            mode    = idle_mode_t'(k / PHASE_WORDS);
            do_load = ($urandom_range(99) < 30)
                      || (RANDOM_WORDS - k <= TARGET_LOADS - loads);
            pick    = $urandom_range(99);
            if (pick < (do_load ? 40 : 65))
            begin
                src = loaded_words[$urandom_range(loaded_words.size() - 1)];
                len = src.len;
                w   = shuffled(src.letters, len);
                if (len == MAX_LETTERS && $urandom_range(3) == 0)
                    len = 7;
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, MAX_LETTERS);
                w   = random_letters(len, 1'b0);
            end
            else
            begin
                len = $urandom_range(7);
                w   = random_letters(len, 1'b1);
            end
            if ($urandom_range(1) == 0)
                w = with_junk(w, len);
            if (do_load)
                loads++;
            queue_word(do_load ? OP_LOAD : OP_QUERY, w, len,
                       (k % PHASE_WORDS) == 0, mode);
        end
        total = word_backlog.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Every word accepted, so every answer it owes is already queued.
        while (sent_count < total)
            @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/adm_pkg.sv
rtl/adm_sorter.sv
rtl/adm_table.sv
rtl/anagram_dictionary_match.sv
verif/anagram_dictionary_match_tb.sv
